// ----- hdl/psns_pkg.sv -----
// Shared types and constants for the point store nearest-search block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package psns_pkg;

    // Store geometry and coordinate format
    localparam int MAX_POINTS = 1024;
    localparam int COORD_W    = 16;
    localparam int INDEX_W    = $clog2(MAX_POINTS);
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

    // Distance datapath widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W - 1;
    localparam int SUM_W  = SQ_W + 2;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_LOCATE = 1'b1
    } psns_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } psns_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } psns_point_t;

    // One input transaction
    typedef struct packed {
        psns_op_t                  op;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } psns_item_t;

    // One result transaction
    typedef struct packed {
        logic [INDEX_W-1:0]        point_index;
        logic                      ok;
        logic [COUNT_W-1:0]        point_count;
        logic                      box_valid;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } psns_result_t;

    // Request from the sequencer to the distance unit
    typedef struct packed {
        logic               clear;
        logic               valid;
        logic [INDEX_W-1:0] index;
    } psns_dist_req_t;

    // Status back from the distance unit
    typedef struct packed {
        logic               pending;
        logic [INDEX_W-1:0] best_index;
    } psns_dist_stat_t;

endpackage

`default_nettype wire

// ----- hdl/psns_point_mem.sv -----
// Point storage: one write port, one registered read port.
// Depends on psns_pkg for depth and the point type.
`default_nettype none

module psns_point_mem (
    input  wire                            clk,
    input  wire                            wr_en,
    input  wire [psns_pkg::INDEX_W-1:0]    wr_addr,
    input  wire psns_pkg::psns_point_t     wr_data,
    input  wire [psns_pkg::INDEX_W-1:0]    rd_addr,
    output psns_pkg::psns_point_t          rd_data
);

    psns_pkg::psns_point_t mem [psns_pkg::MAX_POINTS];
    psns_pkg::psns_point_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/psns_dist_unit.sv -----
// Pipelined squared-distance unit with running minimum, one point per cycle.
// Depends on psns_pkg; fed by psns_point_mem read data in the cycle after the request.
`default_nettype none

module psns_dist_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire psns_pkg::psns_point_t    query,
    input  wire psns_pkg::psns_dist_req_t req,
    input  wire psns_pkg::psns_point_t    point,
    output psns_pkg::psns_dist_stat_t     stat
);

    // Stage 0: request aligned with memory read latency
    logic                            s0_valid_reg;
    logic [psns_pkg::INDEX_W-1:0]    s0_index_reg;
    // Stage 1: per-axis differences
    logic                            s1_valid_reg;
    logic [psns_pkg::INDEX_W-1:0]    s1_index_reg;
    logic signed [psns_pkg::DIFF_W-1:0] s1_dx_reg;
    logic signed [psns_pkg::DIFF_W-1:0] s1_dy_reg;
    logic signed [psns_pkg::DIFF_W-1:0] s1_dz_reg;
    // Stage 2: per-axis squares
    logic                            s2_valid_reg;
    logic [psns_pkg::INDEX_W-1:0]    s2_index_reg;
    logic [psns_pkg::SQ_W-1:0]       s2_sx_reg;
    logic [psns_pkg::SQ_W-1:0]       s2_sy_reg;
    logic [psns_pkg::SQ_W-1:0]       s2_sz_reg;
    // Stage 3: summed distance
    logic                            s3_valid_reg;
    logic [psns_pkg::INDEX_W-1:0]    s3_index_reg;
    logic [psns_pkg::SUM_W-1:0]      s3_sum_reg;
    // Running best
    logic                            first_reg;
    logic [psns_pkg::SUM_W-1:0]      best_dist_reg;
    logic [psns_pkg::INDEX_W-1:0]    best_index_reg;

    logic signed [2*psns_pkg::DIFF_W-1:0] prod_x;
    logic signed [2*psns_pkg::DIFF_W-1:0] prod_y;
    logic signed [2*psns_pkg::DIFF_W-1:0] prod_z;

    // Squares of the registered differences
    always_comb
    begin
        prod_x = s1_dx_reg * s1_dx_reg;
        prod_y = s1_dy_reg * s1_dy_reg;
        prod_z = s1_dz_reg * s1_dz_reg;
    end

    // Valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= req.valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        s0_index_reg <= req.index;

        s1_index_reg <= s0_index_reg;
        s1_dx_reg    <= psns_pkg::DIFF_W'(query.x) - psns_pkg::DIFF_W'(point.x);
        s1_dy_reg    <= psns_pkg::DIFF_W'(query.y) - psns_pkg::DIFF_W'(point.y);
        s1_dz_reg    <= psns_pkg::DIFF_W'(query.z) - psns_pkg::DIFF_W'(point.z);

        s2_index_reg <= s1_index_reg;
        s2_sx_reg    <= prod_x[psns_pkg::SQ_W-1:0];
        s2_sy_reg    <= prod_y[psns_pkg::SQ_W-1:0];
        s2_sz_reg    <= prod_z[psns_pkg::SQ_W-1:0];

        s3_index_reg <= s2_index_reg;
        s3_sum_reg   <= psns_pkg::SUM_W'(s2_sx_reg) + psns_pkg::SUM_W'(s2_sy_reg)
                      + psns_pkg::SUM_W'(s2_sz_reg);
    end

    // Running minimum; strict compare keeps the lower index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg      <= 1'b1;
            best_dist_reg  <= '0;
            best_index_reg <= '0;
        end
        else if (req.clear)
        begin
            first_reg      <= 1'b1;
            best_index_reg <= '0;
        end
        else if (s3_valid_reg && (first_reg || (s3_sum_reg < best_dist_reg)))
        begin
            first_reg      <= 1'b0;
            best_dist_reg  <= s3_sum_reg;
            best_index_reg <= s3_index_reg;
        end
    end

    assign stat.pending    = s0_valid_reg | s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign stat.best_index = best_index_reg;

endmodule

`default_nettype wire

// ----- hdl/point_store_nearest_search_unit.sv -----
// Top level: sequencer, point count and bounding box, result register.
// Depends on psns_pkg, psns_point_mem and psns_dist_unit.
//
//   channel  | signals                 | transfer
//   ---------+-------------------------+-----------------------------------
//   input    | start, busy, item       | taken at an edge with start & !busy
//   result   | done, result            | done high for one cycle per transaction
//
// Add, and locate on an empty store: result strobes in the cycle after accept.
// Locate: the distance pipeline reads one stored point per cycle in ST_SCAN, then
// drains in ST_DRAIN before the result strobes; busy stays high until then.
// Reset clears count, box and control; point storage is not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none

module point_store_nearest_search_unit (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire psns_pkg::psns_item_t   item,
    output logic                        done,
    output psns_pkg::psns_result_t      result
);

    psns_pkg::psns_state_t          state_reg;
    psns_pkg::psns_state_t          state_next;
    logic [psns_pkg::INDEX_W-1:0]   scan_idx_reg;
    logic [psns_pkg::INDEX_W-1:0]   scan_idx_next;
    logic [psns_pkg::COUNT_W-1:0]   count_reg;
    psns_pkg::psns_point_t          box_lo_reg;
    psns_pkg::psns_point_t          box_hi_reg;
    psns_pkg::psns_point_t          query_reg;
    psns_pkg::psns_result_t         result_reg;
    logic                           done_reg;

    psns_pkg::psns_point_t          in_point;
    psns_pkg::psns_point_t          rd_point;
    psns_pkg::psns_dist_req_t       dist_req;
    psns_pkg::psns_dist_stat_t      dist_stat;
    logic                           accept;
    logic                           full;
    logic                           do_add;
    logic                           scan_last;
    logic                           scan_finish;

    assign in_point.x  = item.x_coord;
    assign in_point.y  = item.y_coord;
    assign in_point.z  = item.z_coord;
    assign accept      = start && (state_reg == psns_pkg::ST_IDLE);
    assign full        = (count_reg == psns_pkg::COUNT_W'(psns_pkg::MAX_POINTS));
    assign do_add      = accept && (item.op == psns_pkg::OP_ADD) && !full;
    assign scan_last   = (psns_pkg::COUNT_W'(psns_pkg::COUNT_W'(scan_idx_reg) + 1'b1)
                          == count_reg);
    assign scan_finish = (state_reg == psns_pkg::ST_DRAIN) && !dist_stat.pending;

    // Point storage
    psns_point_mem u_mem (
        .clk     (clk),
        .wr_en   (do_add),
        .wr_addr (count_reg[psns_pkg::INDEX_W-1:0]),
        .wr_data (in_point),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_point)
    );

    // Shared distance and minimum unit
    psns_dist_unit u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .query (query_reg),
        .req   (dist_req),
        .point (rd_point),
        .stat  (dist_stat)
    );

    // Sequencer: next state and scan requests
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        dist_req.clear = 1'b0;
        dist_req.valid = 1'b0;
        dist_req.index = scan_idx_reg;
        case (state_reg)
            psns_pkg::ST_IDLE:
            begin
                if (accept && (item.op == psns_pkg::OP_LOCATE) && (count_reg != '0))
                begin
                    state_next     = psns_pkg::ST_SCAN;
                    scan_idx_next  = '0;
                    dist_req.clear = 1'b1;
                end
            end
            psns_pkg::ST_SCAN:
            begin
                dist_req.valid = 1'b1;
                if (scan_last)
                begin
                    state_next = psns_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            psns_pkg::ST_DRAIN:
            begin
                if (!dist_stat.pending)
                begin
                    state_next = psns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psns_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= psns_pkg::ST_IDLE;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    // Count and bounding box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            box_lo_reg <= '0;
            box_hi_reg <= '0;
        end
        else if (do_add)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == '0)
            begin
                box_lo_reg <= in_point;
                box_hi_reg <= in_point;
            end
            else
            begin
                if (in_point.x < box_lo_reg.x) box_lo_reg.x <= in_point.x;
                if (in_point.y < box_lo_reg.y) box_lo_reg.y <= in_point.y;
                if (in_point.z < box_lo_reg.z) box_lo_reg.z <= in_point.z;
                if (in_point.x > box_hi_reg.x) box_hi_reg.x <= in_point.x;
                if (in_point.y > box_hi_reg.y) box_hi_reg.y <= in_point.y;
                if (in_point.z > box_hi_reg.z) box_hi_reg.z <= in_point.z;
            end
        end
    end

    // Query latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= in_point;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (accept && !((item.op == psns_pkg::OP_LOCATE) && (count_reg != '0)))
                        || scan_finish;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg.point_index <= do_add ? count_reg[psns_pkg::INDEX_W-1:0] : '0;
            result_reg.ok          <= do_add;
            result_reg.point_count <= do_add ? psns_pkg::COUNT_W'(count_reg + 1'b1)
                                             : count_reg;
            result_reg.box_valid   <= do_add || (count_reg != '0);
        end
        else if (scan_finish)
        begin
            result_reg.point_index <= dist_stat.best_index;
            result_reg.ok          <= 1'b1;
            result_reg.point_count <= count_reg;
            result_reg.box_valid   <= 1'b1;
        end
    end

    // Box fields follow the committed box
    assign result.point_index = result_reg.point_index;
    assign result.ok          = result_reg.ok;
    assign result.point_count = result_reg.point_count;
    assign result.box_valid   = result_reg.box_valid;
    assign result.min_x       = box_lo_reg.x;
    assign result.min_y       = box_lo_reg.y;
    assign result.min_z       = box_lo_reg.z;
    assign result.max_x       = box_hi_reg.x;
    assign result.max_y       = box_hi_reg.y;
    assign result.max_z       = box_hi_reg.z;

    assign busy = (state_reg != psns_pkg::ST_IDLE);
    assign done = done_reg;

    // Checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == psns_pkg::OP_ADD)) |=> done)
        else $error("add transaction did not complete in one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.point_count <= psns_pkg::COUNT_W'(psns_pkg::MAX_POINTS)))
        else $error("point count above capacity");

    a_box_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.box_valid == (result.point_count != '0)))
        else $error("box valid disagrees with count");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.ok) |->
            (psns_pkg::COUNT_W'(result.point_index) < result.point_count))
        else $error("reported index outside stored points");

endmodule

`default_nettype wire
